[src/bbce_pkg.sv]
package bbce_pkg;

   localparam int unsigned EntriesDefault = 64;

   localparam int unsigned KeyWidth   = 32;
   localparam int unsigned BytesWidth = 48;
   localparam int unsigned CapWidth   = 7;
   localparam int unsigned CntWidth   = 32;
   localparam int unsigned CsrWidth   = 48;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [CsrIdxWidth-1:0] CSR_BYTE_BUDGET = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_ADMIT_MODE  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_EVICT_CAP   = 2'd2;

   localparam logic [BytesWidth-1:0] BUDGET_RESET = 48'd1073741824;
   localparam logic                  MODE_RESET   = 1'b1;
   localparam logic [CapWidth-1:0]   CAP_RESET    = 7'd3;

   localparam logic [CapWidth-1:0] EVC_MAX = 7'd127;
   localparam logic [CntWidth-1:0] CNT_MAX = 32'hFFFF_FFFF;

endpackage

[src/byte_budget_cache_eviction.sv]
// Size-aware FIFO cache admission with a byte budget. Pulse start while busy is low to
// submit a request; exactly one response follows, shown for a single cycle with
// rsp_valid, and it cannot be held off, so capture it when it appears. Entries live
// in a circular buffer in insertion order, so eviction always pops the oldest. A
// request first scans the cached keys from the oldest, one memory read per cycle,
// until a key matches or all are checked; an empty table skips the scan. A loadable
// miss then evicts or pre-checks the oldest entries one at a time, inserts the entry
// if it fits, and responds. Configuration must be written only while busy is low.
module byte_budget_cache_eviction #(
   parameter int unsigned ENTRIES = bbce_pkg::EntriesDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [bbce_pkg::KeyWidth-1:0]   req_key,
   input  logic [bbce_pkg::BytesWidth-1:0] req_entry_bytes,
   input  logic                            req_loadable,
   output logic                            rsp_valid,
   output logic                            rsp_hit,
   output logic                            rsp_inserted,
   output logic                            rsp_direct_load,
   output logic [bbce_pkg::CapWidth-1:0]   rsp_evicted_count,
   output logic [bbce_pkg::BytesWidth-1:0] rsp_bytes_in_use,
   output logic [bbce_pkg::CntWidth-1:0]   rsp_hit_total,
   output logic [bbce_pkg::CntWidth-1:0]   rsp_miss_total,
   output logic [bbce_pkg::CntWidth-1:0]   rsp_direct_total,
   input  logic                            csr_we,
   input  logic [bbce_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [bbce_pkg::CsrWidth-1:0]   csr_wdata
);
   import bbce_pkg::*;

   localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam int unsigned SW = AW + 8;
   localparam logic [CW-1:0] ENTRIES_C = CW'(ENTRIES);
   localparam logic [SW-1:0] ENTRIES_S = SW'(ENTRIES);

   typedef enum logic [3:0] {
      S_IDLE, S_SEARCH, S_MISS, S_EV0, S_EV0W, S_CHK, S_CHKW, S_INS, S_FIN
   } state_type;

   state_type              state_ff;
   logic [BytesWidth-1:0]  budget_ff;
   logic                   mode_ff;
   logic [CapWidth-1:0]    cap_ff;

   logic [KeyWidth-1:0]    key_mem [ENTRIES];
   logic [BytesWidth-1:0]  bytes_mem [ENTRIES];
   logic [KeyWidth-1:0]    key_q_ff;
   logic [BytesWidth-1:0]  bytes_q_ff;
   logic                   rv_ff;

   logic [AW-1:0]          head_ff;
   logic [CW-1:0]          count_ff;
   logic [BytesWidth-1:0]  used_ff;
   logic [CntWidth-1:0]    hit_cnt_ff, miss_cnt_ff, dir_cnt_ff;

   logic [KeyWidth-1:0]    key_ff;
   logic [BytesWidth-1:0]  need_ff;
   logic                   load_ff;
   logic [CW-1:0]          issue_ff, chk_ff, crem_ff;
   logic [BytesWidth-1:0]  rem_ff;
   logic [CapWidth-1:0]    n_ff;
   logic                   hit_ff, ins_ff, dir_ff, out_valid_ff;
   logic [CapWidth-1:0]    evc_ff;

   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic                   fit_used, fit_rem, chk_loop;

   function automatic logic [AW-1:0] wrap(input logic [SW-1:0] v);
      logic [SW-1:0] r;
      r = (v >= ENTRIES_S) ? v - ENTRIES_S : v;
      return r[AW-1:0];
   endfunction

   function automatic logic fits(input logic [BytesWidth-1:0] used,
                                 input logic [BytesWidth-1:0] need,
                                 input logic [BytesWidth-1:0] budget,
                                 input logic [CW-1:0] cnt);
      logic [BytesWidth:0] sum;
      sum = {1'b0, used} + {1'b0, need};
      return (sum <= {1'b0, budget}) && (cnt < ENTRIES_C);
   endfunction

   assign fit_used = fits(used_ff, need_ff, budget_ff, count_ff);
   assign fit_rem  = fits(rem_ff, need_ff, budget_ff, crem_ff);
   assign chk_loop = (crem_ff != '0) && (n_ff < cap_ff) && !fit_rem;

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = head_ff;
      case (state_ff)
         S_SEARCH: begin
            rd_en   = issue_ff < count_ff;
            rd_addr = wrap(SW'(head_ff) + SW'(issue_ff));
         end
         S_EV0: begin
            rd_en   = !fit_used && (count_ff != '0);
            rd_addr = head_ff;
         end
         S_CHK: begin
            rd_en   = chk_loop;
            rd_addr = wrap(SW'(head_ff) + SW'(n_ff));
         end
         default: begin
            rd_en   = 1'b0;
            rd_addr = head_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         key_q_ff   <= key_mem[rd_addr];
         bytes_q_ff <= bytes_mem[rd_addr];
      end
      if (state_ff == S_INS) begin
         key_mem[wrap(SW'(head_ff) + SW'(count_ff))]   <= key_ff;
         bytes_mem[wrap(SW'(head_ff) + SW'(count_ff))] <= need_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         budget_ff    <= BUDGET_RESET;
         mode_ff      <= MODE_RESET;
         cap_ff       <= CAP_RESET;
         rv_ff        <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         used_ff      <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         dir_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rv_ff        <= rd_en;
         out_valid_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_BYTE_BUDGET: budget_ff <= csr_wdata;
               CSR_ADMIT_MODE:  mode_ff   <= csr_wdata[0];
               CSR_EVICT_CAP:   cap_ff    <= csr_wdata[CapWidth-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  key_ff   <= req_key;
                  need_ff  <= req_entry_bytes;
                  load_ff  <= req_loadable;
                  hit_ff   <= 1'b0;
                  ins_ff   <= 1'b0;
                  dir_ff   <= 1'b0;
                  evc_ff   <= '0;
                  issue_ff <= '0;
                  chk_ff   <= '0;
                  state_ff <= (count_ff == '0) ? S_MISS : S_SEARCH;
               end
            end
            S_SEARCH: begin
               if (rd_en) issue_ff <= issue_ff + 1'b1;
               if (rv_ff) begin
                  if (key_q_ff == key_ff) begin
                     hit_ff <= 1'b1;
                     if (mode_ff && hit_cnt_ff != CNT_MAX) hit_cnt_ff <= hit_cnt_ff + 1'b1;
                     state_ff <= S_FIN;
                  end else if (chk_ff + 1'b1 == count_ff) begin
                     state_ff <= S_MISS;
                  end else begin
                     chk_ff <= chk_ff + 1'b1;
                  end
               end
            end
            S_MISS: begin
               if (mode_ff && miss_cnt_ff != CNT_MAX) miss_cnt_ff <= miss_cnt_ff + 1'b1;
               rem_ff  <= used_ff;
               crem_ff <= count_ff;
               n_ff    <= '0;
               if (!load_ff) begin
                  state_ff <= S_FIN;
               end else if (!mode_ff) begin
                  state_ff <= S_EV0;
               end else if (fit_used) begin
                  state_ff <= S_INS;
               end else if (count_ff == '0) begin
                  dir_ff <= 1'b1;
                  if (dir_cnt_ff != CNT_MAX) dir_cnt_ff <= dir_cnt_ff + 1'b1;
                  state_ff <= S_FIN;
               end else begin
                  state_ff <= S_CHK;
               end
            end
            S_EV0: begin
               if (fit_used) state_ff <= S_INS;
               else if (count_ff == '0) state_ff <= S_FIN;
               else state_ff <= S_EV0W;
            end
            S_EV0W: begin
               used_ff  <= used_ff - bytes_q_ff;
               head_ff  <= wrap(SW'(head_ff) + SW'(1));
               count_ff <= count_ff - 1'b1;
               if (evc_ff != EVC_MAX) evc_ff <= evc_ff + 1'b1;
               state_ff <= S_EV0;
            end
            S_CHK: begin
               if (chk_loop) begin
                  state_ff <= S_CHKW;
               end else if (fit_rem) begin
                  used_ff  <= rem_ff;
                  head_ff  <= wrap(SW'(head_ff) + SW'(n_ff));
                  count_ff <= crem_ff;
                  evc_ff   <= n_ff;
                  state_ff <= S_INS;
               end else begin
                  dir_ff <= 1'b1;
                  if (dir_cnt_ff != CNT_MAX) dir_cnt_ff <= dir_cnt_ff + 1'b1;
                  state_ff <= S_FIN;
               end
            end
            S_CHKW: begin
               rem_ff   <= rem_ff - bytes_q_ff;
               crem_ff  <= crem_ff - 1'b1;
               n_ff     <= n_ff + 1'b1;
               state_ff <= S_CHK;
            end
            S_INS: begin
               count_ff <= count_ff + 1'b1;
               used_ff  <= used_ff + need_ff;
               ins_ff   <= 1'b1;
               state_ff <= S_FIN;
            end
            S_FIN: begin
               out_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy              = state_ff != S_IDLE;
   assign rsp_valid         = out_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_inserted      = ins_ff;
   assign rsp_direct_load   = dir_ff;
   assign rsp_evicted_count = evc_ff;
   assign rsp_bytes_in_use  = used_ff;
   assign rsp_hit_total     = hit_cnt_ff;
   assign rsp_miss_total    = miss_cnt_ff;
   assign rsp_direct_total  = dir_cnt_ff;

endmodule

[test/tb.sv]
module tb;
   import bbce_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned Slots = EntriesDefault;

   typedef struct {
      logic [KeyWidth-1:0]   key;
      logic [BytesWidth-1:0] nbytes;
   } line_type;

   typedef struct {
      logic                  hit;
      logic                  inserted;
      logic                  direct_load;
      logic [CapWidth-1:0]   evicted;
      logic [BytesWidth-1:0] in_use;
      logic [CntWidth-1:0]   hits;
      logic [CntWidth-1:0]   misses;
      logic [CntWidth-1:0]   directs;
   } outcome_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [KeyWidth-1:0]     req_key = '0;
   logic [BytesWidth-1:0]   req_entry_bytes = '0;
   logic                    req_loadable = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_hit;
   logic                    rsp_inserted;
   logic                    rsp_direct_load;
   logic [CapWidth-1:0]     rsp_evicted_count;
   logic [BytesWidth-1:0]   rsp_bytes_in_use;
   logic [CntWidth-1:0]     rsp_hit_total;
   logic [CntWidth-1:0]     rsp_miss_total;
   logic [CntWidth-1:0]     rsp_direct_total;
   logic                    csr_we = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index = '0;
   logic [CsrWidth-1:0]     csr_wdata = '0;

   // cache image: index 0 is the oldest insertion
   line_type                lines_q[$];
   longint unsigned         used_bytes;
   logic [BytesWidth-1:0]   budget_r;
   logic                    mode_r;
   logic [CapWidth-1:0]     cap_r;
   logic [CntWidth-1:0]     hit_cnt, miss_cnt, direct_cnt;
   outcome_type             expected_q[$];
   int                      mismatches = 0;

   byte_budget_cache_eviction DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #50ms;
      $display("Test completed with failures");
      $finish;
   end

   function automatic bit fits(longint unsigned used, longint unsigned b, int cnt);
      return (used + b <= longint'(budget_r)) && (cnt < Slots);
   endfunction

   function automatic logic [CntWidth-1:0] sat_inc(logic [CntWidth-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
   endfunction

   function automatic void predict_outcome(logic [KeyWidth-1:0] key,
                                           logic [BytesWidth-1:0] b, logic ld);
      outcome_type     o;
      bit              found;
      int              cnt, n, evicted;
      longint unsigned freed;
      line_type        ln;
      line_type        oldest;
      o = '{default: '0};
      found = 0;
      evicted = 0;
      foreach (lines_q[i]) if (lines_q[i].key == key) found = 1;
      cnt = lines_q.size();
      if (found) begin
         o.hit = 1;
         if (mode_r) hit_cnt = sat_inc(hit_cnt);
      end else begin
         if (mode_r) miss_cnt = sat_inc(miss_cnt);
         ln.key = key;
         ln.nbytes = b;
         if (ld) begin
            if (!mode_r) begin
               while (cnt > 0 && !fits(used_bytes, b, cnt)) begin
                  oldest = lines_q.pop_front();
                  used_bytes -= oldest.nbytes;
                  cnt--;
                  evicted++;
               end
               if (fits(used_bytes, b, cnt)) begin
                  lines_q = {lines_q, ln};
                  used_bytes += b;
                  o.inserted = 1;
               end
            end else if (fits(used_bytes, b, cnt)) begin
               lines_q = {lines_q, ln};
               used_bytes += b;
               o.inserted = 1;
            end else begin
               freed = 0;
               n = 0;
               if (cnt > 0) begin
                  while (n < cnt && n < int'(cap_r) &&
                         !fits(used_bytes - freed, b, cnt - n)) begin
                     freed += lines_q[n].nbytes;
                     n++;
                  end
               end
               if (cnt > 0 && fits(used_bytes - freed, b, cnt - n)) begin
                  repeat (n) void'(lines_q.pop_front());
                  used_bytes = used_bytes - freed + b;
                  lines_q = {lines_q, ln};
                  evicted = n;
                  o.inserted = 1;
               end else begin
                  o.direct_load = 1;
                  direct_cnt = sat_inc(direct_cnt);
               end
            end
         end
      end
      o.evicted = (evicted > 127) ? EVC_MAX : CapWidth'(evicted);
      o.in_use = BytesWidth'(used_bytes);
      o.hits = hit_cnt;
      o.misses = miss_cnt;
      o.directs = direct_cnt;
      expected_q = {expected_q, o};
   endfunction

   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response at %0t", $realtime);
         end else begin
            e = expected_q.pop_front();
            if (rsp_hit !== e.hit || rsp_inserted !== e.inserted ||
                rsp_direct_load !== e.direct_load || rsp_evicted_count !== e.evicted ||
                rsp_bytes_in_use !== e.in_use || rsp_hit_total !== e.hits ||
                rsp_miss_total !== e.misses || rsp_direct_total !== e.directs) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: exp h%0b i%0b d%0b ev%0d use%0d %0d/%0d/%0d, got h%0b i%0b d%0b ev%0d use%0d %0d/%0d/%0d",
                     $realtime, e.hit, e.inserted, e.direct_load, e.evicted, e.in_use,
                     e.hits, e.misses, e.directs, rsp_hit, rsp_inserted,
                     rsp_direct_load, rsp_evicted_count, rsp_bytes_in_use,
                     rsp_hit_total, rsp_miss_total, rsp_direct_total);
            end
         end
      end
   end

   task automatic send_request(logic [KeyWidth-1:0] key, logic [BytesWidth-1:0] b,
                               logic ld);
      int gap;
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_key <= key;
      req_entry_bytes <= b;
      req_loadable <= ld;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_outcome(key, b, ld);
   endtask

   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0 || busy) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(logic [CsrIdxWidth-1:0] idx, logic [CsrWidth-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_BYTE_BUDGET: budget_r = data;
         CSR_ADMIT_MODE:  mode_r = data[0];
         CSR_EVICT_CAP:   cap_r = data[CapWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic test_mode1_directed;
      send_request(32'h0, 48'h0, 1'b1);
      send_request(32'h0, 48'h0, 1'b1);
      send_request(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
      send_request(32'h5, 48'hFFFF_FFFF_FFFF, 1'b1);
      send_request(32'h6, 48'd1073741824, 1'b1);
      send_request(32'h7, 48'd100, 1'b1);
      drain();
      csr_write(CSR_BYTE_BUDGET, 48'd0);
      send_request(32'h8, 48'd1, 1'b1);
      send_request(32'h8, 48'd0, 1'b1);
      drain();
      csr_write(CSR_EVICT_CAP, 48'd0);
      csr_write(CSR_BYTE_BUDGET, 48'd50);
      send_request(32'h9, 48'd50, 1'b1);
      send_request(32'hA, 48'd1, 1'b1);
      drain();
   endtask

   task automatic test_mode0_directed;
      csr_write(CSR_ADMIT_MODE, 48'd0);
      csr_write(CSR_BYTE_BUDGET, 48'd1000);
      send_request(32'h10, 48'd400, 1'b1);
      send_request(32'h11, 48'd400, 1'b1);
      send_request(32'h12, 48'd300, 1'b1);
      send_request(32'h11, 48'd1, 1'b1);
      send_request(32'h13, 48'd5, 1'b0);
      send_request(32'h14, 48'd2000, 1'b1);
      send_request(32'h15, 48'd1000, 1'b1);
      drain();
      csr_write(CSR_BYTE_BUDGET, 48'hFFFF_FFFF_FFFF);
      send_request(32'h16, 48'hFFFF_FFFF_FFFF, 1'b1);
      send_request(32'h17, 48'h1, 1'b1);
      drain();
   endtask

   task automatic test_random_traffic;
      logic [BytesWidth-1:0] b, lim;
      logic [KeyWidth-1:0]   key;
      int                    sel;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: lim = 48'hFFFF_FFFF_FFFF;
            1: lim = BytesWidth'($urandom_range(0, 5000));
            2: lim = BytesWidth'({$urandom, $urandom});
            default: lim = BytesWidth'($urandom_range(1000, 100000));
         endcase
         csr_write(CSR_BYTE_BUDGET, lim);
         csr_write(CSR_ADMIT_MODE, ph[0] ? 48'd0 : 48'd1);
         case ($urandom_range(0, 4))
            0: sel = 0;
            1: sel = 1;
            2: sel = 64;
            3: sel = 127;
            default: sel = $urandom_range(2, 10);
         endcase
         csr_write(CSR_EVICT_CAP, CsrWidth'(sel));
         for (int k = 0; k < 115; k++) begin
            key = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 120);
            sel = $urandom_range(0, 9);
            if (sel == 0) b = BytesWidth'({$urandom, $urandom});
            else if (lim == 48'hFFFF_FFFF_FFFF) b = BytesWidth'($urandom_range(0, 1000));
            else b = BytesWidth'((longint'(lim) / 6) * $urandom_range(0, 100) / 100);
            send_request(key, b, $urandom_range(0, 9) != 0);
         end
         drain();
      end
   endtask

   initial begin
      budget_r = BUDGET_RESET;
      mode_r = MODE_RESET;
      cap_r = CAP_RESET;
      used_bytes = 0;
      hit_cnt = '0;
      miss_cnt = '0;
      direct_cnt = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_mode1_directed();
      test_mode0_directed();
      test_random_traffic();
      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

[byte_budget_cache_eviction.f]
src/bbce_pkg.sv
src/byte_budget_cache_eviction.sv
test/tb.sv
